[sv/pls_pkg.sv]
// Shared types and constants for the positional list store.
// Used by pls_cell and positional_list_store; no dependencies.
package pls_pkg;

  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefDataWidth = 32;

  localparam int unsigned OpWidth   = 2;
  localparam int unsigned PosWidth  = 5;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned CntOut    = 5;

  typedef enum logic [OpWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // per-cell control, decoded for each cell in the top level
  typedef struct packed {
    logic ins;   // committed insert this cycle
    logic rem;   // committed remove this cycle
    logic at;    // cell index equals the target position
    logic past;  // cell index is above the target position
  } cell_ctrl_t;

endpackage

[sv/pls_cell.sv]
// One storage cell of the positional list: holds a word and shifts with
// its neighbors. Depends on pls_pkg.
module pls_cell #(
  parameter int unsigned DataWidth = pls_pkg::DefDataWidth
) (
  input  logic                    clk_i,
  input  pls_pkg::cell_ctrl_t     ctrl_i,
  input  logic [DataWidth-1:0]    new_i,    // word being inserted
  input  logic [DataWidth-1:0]    lower_i,  // neighbor one place down
  input  logic [DataWidth-1:0]    upper_i,  // neighbor one place up
  output logic [DataWidth-1:0]    word_o,
  output logic [DataWidth-1:0]    rd_o      // own word when addressed, else zero
);
  import pls_pkg::*;

  logic [DataWidth-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (ctrl_i.at) begin
        word_d = new_i;
      end else if (ctrl_i.past) begin
        word_d = lower_i;
      end
    end else if (ctrl_i.rem) begin
      if (ctrl_i.at || ctrl_i.past) begin
        word_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = ctrl_i.at ? word_q : '0;

endmodule

[sv/positional_list_store.sv]
// Positional list store: a row of pls_cell words plus count and result logic.
// Latency: a result is valid the cycle after its beat is accepted.
// Throughput: one beat per cycle while the input is ready; all cells shift together in that cycle.
// A new beat is taken while the result register is empty or being drained.
// Reset clears the count and the result valid flag; stored words are not cleared
// and stay unseen until written. Depends on pls_pkg and pls_cell.
module positional_list_store #(
  parameter int unsigned CAPACITY   = pls_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = pls_pkg::DefDataWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [4:0] position, [36:5] data_in, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data_out, [36:32] entry_count,
                                      // [37] is_empty, rest zero
  output logic        m_axis_tuser    // [0] ok
);
  import pls_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  // common width for comparing the position against count and cell indexes
  localparam int unsigned CmpW = (CntW > PosWidth) ? CntW : PosWidth;

  // ---------------------------------------------------------------------
  // Beat decode
  // ---------------------------------------------------------------------
  op_e                  op;
  logic [PosWidth-1:0]  pos;
  logic [WordWidth-1:0] din;
  logic [CmpW-1:0]      pos_c;
  logic [CmpW-1:0]      cnt_c;
  logic                 in_fire;

  assign op      = op_e'(s_axis_tuser);
  assign pos     = s_axis_tdata[PosWidth-1:0];
  assign din     = s_axis_tdata[PosWidth+WordWidth-1:PosWidth];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Count register; only control state here gets a reset.
  logic [CntW-1:0] cnt_q, cnt_d;

  assign pos_c = CmpW'(pos);
  assign cnt_c = CmpW'(cnt_q);

  // Validity of each operation against the current count.
  logic ins_ok, rem_ok, rd_ok, ok;
  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    rd_ok  = 1'b0;
    case (op)
      OP_INSERT: ins_ok = (pos_c <= cnt_c) && (cnt_q != CntW'(CAPACITY));
      OP_REMOVE: rem_ok = pos_c < cnt_c;
      OP_READ:   rd_ok  = pos_c < cnt_c;
      default: ;  // unused code: fails, no change
    endcase
  end
  assign ok = ins_ok || rem_ok || rd_ok;

  always_comb begin
    cnt_d = cnt_q;
    if (in_fire && ins_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (in_fire && rem_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Cell row. Insert: cells above pos take the word below, cell at pos
  // loads the new word. Remove: cells at or above pos take the word above.
  // ---------------------------------------------------------------------
  logic [DATA_WIDTH+WordWidth-1:0] din_w;
  logic [DATA_WIDTH-1:0]           new_word;
  logic [DATA_WIDTH-1:0]           word   [CAPACITY];
  logic [DATA_WIDTH-1:0]           rd_sel [CAPACITY];

  assign din_w    = {{DATA_WIDTH{1'b0}}, din};
  assign new_word = din_w[DATA_WIDTH-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CmpW-1:0] Idx = CmpW'(i);
    cell_ctrl_t           ctrl;
    logic [DATA_WIDTH-1:0] lower, upper;

    assign ctrl.ins  = in_fire && ins_ok;
    assign ctrl.rem  = in_fire && rem_ok;
    assign ctrl.at   = pos_c == Idx;
    assign ctrl.past = pos_c < Idx;

    // bottom cell never shifts up; top cell's upper value is never kept
    if (i == 0) begin : g_lo
      assign lower = new_word;
    end else begin : g_lo_n
      assign lower = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign upper = word[i];
    end else begin : g_hi_n
      assign upper = word[i+1];
    end

    pls_cell #(
      .DataWidth(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .new_i  (new_word),
      .lower_i(lower),
      .upper_i(upper),
      .word_o (word[i]),
      .rd_o   (rd_sel[i])
    );
  end

  // Read port: only the addressed cell drives nonzero, so OR the row.
  logic [DATA_WIDTH-1:0]           rd_word;
  logic [DATA_WIDTH+WordWidth-1:0] rd_w;
  logic [WordWidth-1:0]            rd_out;
  always_comb begin
    rd_word = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | rd_sel[k];
    end
  end
  assign rd_w   = {{WordWidth{1'b0}}, rd_word};
  assign rd_out = rd_ok ? rd_w[WordWidth-1:0] : '0;

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [CntW+CntOut-1:0] cnt_ext;
  logic                   out_vld_q, out_vld_d;
  logic                   out_ok_q;
  logic [WordWidth-1:0]   out_data_q;
  logic [CntOut-1:0]      out_cnt_q;
  logic                   out_empty_q;

  assign cnt_ext       = {{CntOut{1'b0}}, cnt_d};
  assign s_axis_tready = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (in_fire) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_ok_q    <= ok;
      out_data_q  <= rd_out;
      out_cnt_q   <= cnt_ext[CntOut-1:0];
      out_empty_q <= cnt_d == '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {2'b00, out_empty_q, out_cnt_q, out_data_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("count above capacity");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ins_ok) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not grow count");

  a_rem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && rem_ok) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("remove did not shrink count");

  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !ok) |=> ($stable(cnt_q) && !out_ok_q && out_vld_q))
    else $error("failed beat changed state");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

[sim/list_result_checker.sv]
// Result checker for the positional list store: watches both stream channels,
// keeps its own copy of the list and compares every result beat with it.
// Depends on pls_pkg for op codes and field widths.
`timescale 1ns / 100ps

module list_result_checker #(
  parameter int unsigned CAPACITY = pls_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,   // [4:0] position, [36:5] data_in, rest zero
  input  logic [1:0]  s_tuser_i,   // [1:0] operation
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // [31:0] data_out, [36:32] entry_count,
                                   // [37] is_empty, rest zero
  input  logic        m_tuser_i,   // [0] ok
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned list_len_o
);
  import pls_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);

  typedef struct packed {
    logic                 ok;
    logic [WordWidth-1:0] word;
    logic [CntOut-1:0]    cnt;
    logic                 empty;
  } list_result_t;

  logic [WordWidth-1:0] shadow_words [CAPACITY];
  int unsigned          shadow_len;
  list_result_t         expected_results [$];
  list_result_t         want;
  list_result_t         got;

  // Applies one operation to the shadow list and returns the result it gives.
  function automatic list_result_t apply_list_op(input logic [OpWidth-1:0] op,
                                                 input logic [PosWidth-1:0] pos,
                                                 input logic [WordWidth-1:0] word);
    list_result_t res;
    int unsigned  i;
    res = '0;
    case (op)
      OP_INSERT: begin
        if (pos <= shadow_len && shadow_len < CAPACITY) begin
          for (i = shadow_len; i > pos; i--) begin
            shadow_words[IdxW'(i)] = shadow_words[IdxW'(i-1)];
          end
          shadow_words[IdxW'(pos)] = word;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_len) begin
          for (i = pos; i + 1 < shadow_len; i++) begin
            shadow_words[IdxW'(i)] = shadow_words[IdxW'(i+1)];
          end
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (pos < shadow_len) begin
          res.word = shadow_words[IdxW'(pos)];
          res.ok   = 1'b1;
        end
      end
      default: ;  // unused code: fails, no change
    endcase
    res.cnt   = CntOut'(shadow_len);
    res.empty = (shadow_len == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      // results trail their beats, so check before predicting
      if (m_tvalid_i && m_tready_i) begin
        got.ok    = m_tuser_i;
        got.word  = m_tdata_i[31:0];
        got.cnt   = m_tdata_i[36:32];
        got.empty = m_tdata_i[37];
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            fail_count_o++;
          end
          if (got.word !== want.word) begin
            $error("data_out: expected %h, actual %h", want.word, got.word);
            fail_count_o++;
          end
          if (got.cnt !== want.cnt) begin
            $error("entry_count: expected %0d, actual %0d", want.cnt, got.cnt);
            fail_count_o++;
          end
          if (got.empty !== want.empty) begin
            $error("is_empty: expected %0d, actual %0d", want.empty, got.empty);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(apply_list_op(s_tuser_i, s_tdata_i[4:0],
                                                 s_tdata_i[36:5]));
      end
    end
    pending_o  = expected_results.size();
    list_len_o = shadow_len;
  end

endmodule

[sim/tb.sv]
// Testbench top for the positional list store: clock, reset, stimulus and
// verdict. Prediction and comparison live in list_result_checker.
// Depends on pls_pkg, positional_list_store and list_result_checker.
`timescale 1ns / 100ps

module tb;
  import pls_pkg::*;

  localparam int unsigned RandomBeats = 950;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;     // long receiver hold-off
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePct     = 28;

  localparam logic [OpWidth-1:0] OpUnused = 2'd3;

  // random mix of operations; cycles every 100 beats
  typedef enum int unsigned {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [4:0] position, [36:5] data_in, rest zero
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] data_out, [36:32] entry_count,
                               // [37] is_empty, rest zero
  logic        m_axis_tuser;   // [0] ok

  int unsigned fail_count;
  int unsigned pending;
  int unsigned list_len;

  // shared knobs: quiet turns idling off on both sides, stall_go starts the
  // one long receiver hold-off
  logic quiet    = 1'b0;
  logic stall_go = 1'b0;

  positional_list_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  list_result_checker #(.CAPACITY(DefCapacity)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, one long hold-off when asked.
  // The hold-off is counted here so the sender keeps pushing meanwhile and
  // the block has to stall its input.
  initial begin : sink
    int unsigned held;
    held          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_go && held < HoldCycles) begin
        m_axis_tready <= 1'b0;
        held++;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Offers one beat, with a random gap first unless quiet. Entered and left
  // at a falling edge; valid is assigned once per step at most.
  task automatic send_beat(input logic [OpWidth-1:0] op,
                           input logic [PosWidth-1:0] pos,
                           input logic [WordWidth-1:0] word);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, word, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back.
  // Always advances at least one step so valid is never re-raised in the
  // step where it was dropped.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [OpWidth-1:0]   op;
    logic [PosWidth-1:0]  pos;
    logic [WordWidth-1:0] word;
    mix_e                 mix;
    int unsigned          r;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: everything fails on an empty list
    send_beat(OP_READ,   5'd0, 32'h0000_0000);
    send_beat(OP_REMOVE, 5'd0, 32'h0000_0000);
    send_beat(OP_INSERT, 5'd1, 32'h1234_5678);  // position above count
    send_beat(OpUnused,  5'd0, 32'hFFFF_FFFF);
    // build a short list, front insert shifts the rest up
    send_beat(OP_INSERT, 5'd0, 32'h0000_0000);
    send_beat(OP_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_beat(OP_INSERT, 5'd0, 32'hA5A5_A5A5);
    send_beat(OP_INSERT, 5'd4, 32'h5A5A_5A5A);  // above count of 3
    send_beat(OP_READ,   5'd0, 32'h0);
    send_beat(OP_READ,   5'd1, 32'h0);
    send_beat(OP_READ,   5'd2, 32'h0);
    send_beat(OP_READ,   5'd3, 32'h0);          // at count
    // middle remove shifts the tail down
    send_beat(OP_REMOVE, 5'd1, 32'h0);
    send_beat(OP_READ,   5'd1, 32'h0);
    send_beat(OP_REMOVE, 5'd31, 32'hFFFF_FFFF);
    send_beat(OpUnused,  5'd31, 32'hFFFF_FFFF);
    send_beat(OP_READ,   5'd16, 32'h0);
    send_beat(OP_INSERT, 5'd2, 32'h8000_0001);  // append at count
    send_beat(OP_REMOVE, 5'd2, 32'h0);          // remove last

    // random: mostly legal positions so the list fills to capacity and
    // empties again; full-list inserts come up in the growing mix
    for (int unsigned i = 0; i < RandomBeats; i++) begin
      if (i == 200 || i == 800) wait_drained();
      quiet    = (i >= 300 && i < 450);
      if (i == 600) stall_go = 1'b1;

      mix = mix_e'((i / 100) % 3);
      r   = $urandom_range(99);
      case (mix)
        MIX_GROW:   op = (r < 65) ? OP_INSERT : (r < 80) ? OP_REMOVE :
                         (r < 96) ? OP_READ : OpUnused;
        MIX_SHRINK: op = (r < 20) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                         (r < 96) ? OP_READ : OpUnused;
        default:    op = (r < 38) ? OP_INSERT : (r < 72) ? OP_REMOVE :
                         (r < 96) ? OP_READ : OpUnused;
      endcase

      if ($urandom_range(99) < 85) begin
        if (op == OP_INSERT) pos = PosWidth'($urandom_range(list_len, 0));
        else if (list_len == 0) pos = '0;
        else pos = PosWidth'($urandom_range(list_len - 1, 0));
      end else begin
        pos = PosWidth'($urandom_range(31, 0));
      end

      r = $urandom_range(9);
      word = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
      send_beat(op, pos, word);
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[positional_list_store.f]
sv/pls_pkg.sv
sv/pls_cell.sv
sv/positional_list_store.sv
sim/list_result_checker.sv
sim/tb.sv
